[hw/rtl/mslfe_pkg.sv]
// ----------------------------------------------------------------------------
// mslfe_pkg
// Shared constants, codes and types of the multi-string LED frame encoder.
// ----------------------------------------------------------------------------
package mslfe_pkg;

  localparam int LED_COUNT    = 64;
  localparam int ROW_COUNT    = 8;
  localparam int BITS_PER_LED = 24;
  localparam int FRAME_BITS   = LED_COUNT * BITS_PER_LED;

  localparam int ADDR_W = $clog2(FRAME_BITS);
  localparam int CUR_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int ROW_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int CNT_W  = $clog2(BITS_PER_LED + 1);

  localparam logic [7:0] ROW_MASK = 8'((1 << ROW_COUNT) - 1);

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_SET    = 3'd2,
    ACT_GET    = 3'd3,
    ACT_START  = 3'd4,
    ACT_TICK   = 3'd5
  } action_t;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BUSY    = 2'd1;
  localparam logic [1:0] STAT_BAD_ROW = 2'd2;

  // Request from the sequencer to the frame store
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              clr_start;
  } store_req_t;

  // Reduce an 8-bit index modulo LED_COUNT by restoring subtraction
  function automatic logic [CUR_W-1:0] led_mod(input logic [7:0] v);
    logic [15:0] r;
    logic [15:0] d;
    r = 16'(v);
    for (int k = 7; k >= 0; k--) begin
      d = 16'(LED_COUNT << k);
      if (r >= d) begin
        r = r - d;
      end
    end
    return CUR_W'(r);
  endfunction

endpackage

[hw/rtl/mslfe_if.sv]
// ----------------------------------------------------------------------------
// mslfe_if
// Valid/ready channels of the frame encoder: command words in, result words out.
// ----------------------------------------------------------------------------
interface mslfe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] string_row;
  logic [7:0] new_index;

  modport source (output valid, action, red, green, blue, string_row, new_index,
                  input ready);
  modport sink (input valid, action, red, green, blue, string_row, new_index,
                output ready);
  modport monitor (input valid, ready, action, red, green, blue, string_row,
                   new_index);
endinterface

interface mslfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pin_levels;
  logic [5:0] cursor_index;
  logic [1:0] status;
  logic       sending;
  logic       last_slot;

  modport source (output valid, pin_levels, cursor_index, status, sending,
                  last_slot, input ready);
  modport sink (input valid, pin_levels, cursor_index, status, sending, last_slot,
                output ready);
  modport monitor (input valid, ready, pin_levels, cursor_index, status, sending,
                   last_slot);
endinterface

[hw/rtl/mslfe_store.sv]
// ----------------------------------------------------------------------------
// mslfe_store
// Bit-plane frame store: one read and one write port, registered read data,
// and a zeroing sweep after reset and on request.
// ----------------------------------------------------------------------------
module mslfe_store (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mslfe_pkg::store_req_t            req,
  output logic [7:0]                       rd_data,
  output logic                             busy
);

  logic [7:0]                    mem [mslfe_pkg::FRAME_BITS];
  logic [7:0]                    rd_data_r;
  logic                          clr_active_r;
  logic [mslfe_pkg::ADDR_W-1:0]  clr_addr_r;

  // Sweep one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == mslfe_pkg::ADDR_W'(mslfe_pkg::FRAME_BITS - 1)) begin
        clr_active_r <= 1'b0;
        clr_addr_r   <= '0;
      end else begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end else if (req.clr_start) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_addr_r] <= 8'd0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_active_r;

endmodule

[hw/rtl/multi_string_led_frame_encoder_unit.sv]
// ----------------------------------------------------------------------------
// multi_string_led_frame_encoder_unit
// Frame encoder for up to eight parallel one-wire addressable RGB LED strings.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and returns exactly one result
// word for it. After reset the frame store is zeroed by a sweep (one entry a
// cycle) during which no command is taken; a clear command runs the same
// sweep before its result appears. add_color merges the color into 24 bit-
// plane entries by a read-modify-write pass over the frame store, one entry
// a cycle, each merge write following in the cycle after its read. set_cursor,
// get_cursor, start_send and an idle or non-data tick go straight from the
// command to the result state; the tick that carries the data plane first
// passes a read state, since it reads the store. The result sits in an output
// register, so a new command is taken while a result waits; the next result
// is held back until the waiting one is taken. Each frame bit is sent as
// four tick slots: all strings high, the data plane, low, low.
// ----------------------------------------------------------------------------
module multi_string_led_frame_encoder_unit (
  input  logic          clk,
  input  logic          rst_n,
  mslfe_in_if.sink      in_ch,
  mslfe_out_if.source   out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_TICK,
    ST_CLEAR,
    ST_DONE
  } state_t;

  state_t                          state_r;

  // Per-string cursors and send position
  logic [mslfe_pkg::CUR_W-1:0]     cursor_r [mslfe_pkg::ROW_COUNT];
  logic                            send_active_r;
  logic [mslfe_pkg::ADDR_W-1:0]    send_bit_r;
  logic [1:0]                      send_phase_r;

  // add_color read-modify-write pass
  logic [mslfe_pkg::ADDR_W-1:0]    add_addr_r;
  logic [mslfe_pkg::CNT_W-1:0]     add_cnt_r;
  logic [23:0]                     color_r;
  logic [7:0]                      sel_r;
  logic                            stg_valid_r;
  logic [mslfe_pkg::ADDR_W-1:0]    stg_addr_r;
  logic                            stg_bit_r;

  // Result under construction and the output register
  logic [7:0]                      res_pins_r;
  logic [5:0]                      res_cur_r;
  logic [1:0]                      res_status_r;
  logic                            res_last_r;
  logic                            out_valid_r;
  logic [7:0]                      out_pins_r;
  logic [5:0]                      out_cur_r;
  logic [1:0]                      out_status_r;
  logic                            out_sending_r;
  logic                            out_last_r;

  mslfe_pkg::store_req_t           store_req;
  logic [7:0]                      store_rd;
  logic                            store_busy;

  logic                            in_acc;
  mslfe_pkg::action_t              act;
  logic                            row_ok;
  logic [mslfe_pkg::ROW_W-1:0]     row_idx;
  logic [mslfe_pkg::CUR_W-1:0]     cur_sel;
  logic [mslfe_pkg::CUR_W-1:0]     cur_next;
  logic [7:0]                      cur_ext;
  logic [7:0]                      row_sel;
  logic [mslfe_pkg::ADDR_W-1:0]    add_base;
  logic                            tick_rd;

  assign in_ch.ready = (state_r == ST_IDLE) && !store_busy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign act         = mslfe_pkg::action_t'(in_ch.action);

  // Decode the target string
  assign row_ok   = in_ch.string_row < 8'(mslfe_pkg::ROW_COUNT);
  assign row_idx  = in_ch.string_row[mslfe_pkg::ROW_W-1:0];
  assign cur_sel  = cursor_r[row_idx];
  assign cur_ext  = 8'(cur_sel);
  assign row_sel  = 8'd1 << row_idx;
  assign add_base = mslfe_pkg::ADDR_W'(cur_sel) *
                    mslfe_pkg::ADDR_W'(mslfe_pkg::BITS_PER_LED);
  assign cur_next = (cur_sel == mslfe_pkg::CUR_W'(mslfe_pkg::LED_COUNT - 1)) ?
                    '0 : cur_sel + 1'b1;

  // Fetch the data plane for the second slot of a bit
  assign tick_rd = in_acc && (act == mslfe_pkg::ACT_TICK) && send_active_r &&
                   (send_phase_r == 2'd1);

  // Store port: add_color reads one entry ahead of the merge write
  always_comb begin
    store_req           = '0;
    store_req.clr_start = in_acc && (act == mslfe_pkg::ACT_CLEAR) && !send_active_r;
    if (state_r == ST_ADD &&
        add_cnt_r != mslfe_pkg::CNT_W'(mslfe_pkg::BITS_PER_LED)) begin
      store_req.rd_en   = 1'b1;
      store_req.rd_addr = add_addr_r;
    end else if (tick_rd) begin
      store_req.rd_en   = 1'b1;
      store_req.rd_addr = send_bit_r;
    end
    if (stg_valid_r) begin
      store_req.wr_en   = 1'b1;
      store_req.wr_addr = stg_addr_r;
      store_req.wr_data = stg_bit_r ? (store_rd | sel_r) : (store_rd & ~sel_r);
    end
  end

  mslfe_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (store_req),
    .rd_data (store_rd),
    .busy    (store_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      send_active_r <= 1'b0;
      send_bit_r    <= '0;
      send_phase_r  <= 2'd0;
      stg_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < mslfe_pkg::ROW_COUNT; i++) begin
        cursor_r[i] <= '0;
      end
    end else begin
      // Drop the output word once taken
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            res_pins_r   <= 8'd0;
            res_cur_r    <= 6'd0;
            res_status_r <= mslfe_pkg::STAT_OK;
            res_last_r   <= 1'b0;
            state_r      <= ST_DONE;
            unique case (act)
              mslfe_pkg::ACT_CLEAR: begin
                if (send_active_r) begin
                  res_status_r <= mslfe_pkg::STAT_BUSY;
                end else begin
                  for (int i = 0; i < mslfe_pkg::ROW_COUNT; i++) begin
                    cursor_r[i] <= '0;
                  end
                  state_r <= ST_CLEAR;
                end
              end
              mslfe_pkg::ACT_ADD: begin
                if (!row_ok) begin
                  res_status_r <= mslfe_pkg::STAT_BAD_ROW;
                end else if (send_active_r) begin
                  res_status_r <= mslfe_pkg::STAT_BUSY;
                end else begin
                  add_addr_r        <= add_base;
                  add_cnt_r         <= '0;
                  color_r           <= {in_ch.green, in_ch.red, in_ch.blue};
                  sel_r             <= row_sel;
                  stg_valid_r       <= 1'b0;
                  cursor_r[row_idx] <= cur_next;
                  state_r           <= ST_ADD;
                end
              end
              mslfe_pkg::ACT_SET: begin
                if (!row_ok) begin
                  res_status_r <= mslfe_pkg::STAT_BAD_ROW;
                end else if (send_active_r) begin
                  res_status_r <= mslfe_pkg::STAT_BUSY;
                end else begin
                  cursor_r[row_idx] <= mslfe_pkg::led_mod(in_ch.new_index);
                end
              end
              mslfe_pkg::ACT_GET: begin
                if (!row_ok) begin
                  res_status_r <= mslfe_pkg::STAT_BAD_ROW;
                end else begin
                  res_cur_r <= cur_ext[5:0];
                end
              end
              mslfe_pkg::ACT_START: begin
                if (send_active_r) begin
                  res_status_r <= mslfe_pkg::STAT_BUSY;
                end else begin
                  send_active_r <= 1'b1;
                  send_bit_r    <= '0;
                  send_phase_r  <= 2'd0;
                end
              end
              mslfe_pkg::ACT_TICK: begin
                if (send_active_r) begin
                  // Slot level: high, data plane (read pending), then low
                  if (send_phase_r == 2'd0) begin
                    res_pins_r <= mslfe_pkg::ROW_MASK;
                  end else if (send_phase_r == 2'd1) begin
                    state_r <= ST_TICK;
                  end
                  // Advance slot, then bit; end of frame stops sending
                  if (send_phase_r == 2'd3) begin
                    send_phase_r <= 2'd0;
                    if (send_bit_r ==
                        mslfe_pkg::ADDR_W'(mslfe_pkg::FRAME_BITS - 1)) begin
                      res_last_r    <= 1'b1;
                      send_active_r <= 1'b0;
                      send_bit_r    <= '0;
                    end else begin
                      send_bit_r <= send_bit_r + 1'b1;
                    end
                  end else begin
                    send_phase_r <= send_phase_r + 2'd1;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end

        ST_ADD: begin
          // Issue the next read and stage its merge bit for the following cycle
          if (add_cnt_r != mslfe_pkg::CNT_W'(mslfe_pkg::BITS_PER_LED)) begin
            add_addr_r  <= add_addr_r + 1'b1;
            add_cnt_r   <= add_cnt_r + 1'b1;
            stg_valid_r <= 1'b1;
            stg_addr_r  <= add_addr_r;
            stg_bit_r   <= color_r[23];
            color_r     <= {color_r[22:0], 1'b0};
          end else begin
            stg_valid_r <= 1'b0;
            state_r     <= ST_DONE;
          end
        end

        ST_TICK: begin
          res_pins_r <= store_rd & mslfe_pkg::ROW_MASK;
          state_r    <= ST_DONE;
        end

        ST_CLEAR: begin
          if (!store_busy) begin
            state_r <= ST_DONE;
          end
        end

        ST_DONE: begin
          // Hand the result over once the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r   <= 1'b1;
            out_pins_r    <= res_pins_r;
            out_cur_r     <= res_cur_r;
            out_status_r  <= res_status_r;
            out_sending_r <= send_active_r;
            out_last_r    <= res_last_r;
            state_r       <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pin_levels   = out_pins_r;
  assign out_ch.cursor_index = out_cur_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.sending      = out_sending_r;
  assign out_ch.last_slot    = out_last_r;

endmodule

[hw/rtl/mslfe_checker.sv]
// ----------------------------------------------------------------------------
// mslfe_checker
// Port-level checks of the frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module mslfe_checker (
  input logic           clk,
  input logic           rst_n,
  mslfe_in_if.sink      in_ch,
  mslfe_out_if.source   out_ch
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      out_ch.valid && $stable(out_ch.pin_levels) && $stable(out_ch.status) &&
      $stable(out_ch.cursor_index) && $stable(out_ch.sending) &&
      $stable(out_ch.last_slot))
    else $error("result word changed while stalled");

  // One command in flight: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("command taken back to back");

  // The final slot is low, accepted and ends the frame
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_slot |->
      !out_ch.sending && out_ch.pin_levels == 8'd0 && out_ch.status == 2'd0)
    else $error("bad final slot");

  // A driven line level only shows up while a frame is still going
  a_pins_sending: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.pin_levels != 8'd0 |-> out_ch.sending)
    else $error("line level outside a frame");

endmodule

bind multi_string_led_frame_encoder_unit mslfe_checker u_mslfe_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-string LED frame encoder. A driver feeds
// command words from a backlog and a monitor checks each result word against
// a local model of the frame store, the string cursors and the tick
// serializer. The stimulus covers directed corners, random edit traffic, and
// a frame started and ticked through its opening bits with edits mixed in,
// with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mslfe_pkg::*;

  // Action codes past the last defined one; the block must treat them as no-ops
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  localparam int unsigned FRAME_SLOTS = FRAME_BITS * 4;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_IDLE_WORDS = 1100;
  localparam int unsigned SEND_TAIL_WORDS = 250;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] string_row;
    logic [7:0] new_index;
  } led_cmd_t;

  typedef struct packed {
    logic [7:0] pins;
    logic [5:0] cursor;
    logic [1:0] status;
    logic       sending;
    logic       last;
  } result_word_t;

  logic clk;
  logic rst_n;

  mslfe_in_if  in_ch ();
  mslfe_out_if out_ch ();

  multi_string_led_frame_encoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // --------------------------------------------------------------------------
  // Local model of the block: bit-plane image, cursors and serializer position
  // --------------------------------------------------------------------------
  logic [7:0]  plane_img [FRAME_BITS];
  int unsigned cursor_img [ROW_COUNT];
  logic        tx_active;
  int unsigned tx_bit;
  int unsigned tx_slot;

  // Command words still to be offered, and result words owed by the block
  led_cmd_t     cmd_backlog [$];
  result_word_t result_words_due [$];

  // Planning state: the stimulus tracks whether a frame is on the wire so it
  // can shape well-formed sequences without looking at the block
  logic        plan_sending;
  int unsigned plan_slots_left;
  longint      run_budget;
  longint      cycle_limit;
  longint      cycle_count;
  int unsigned total_cmds;

  int unsigned cmds_taken;
  int unsigned results_seen;
  int unsigned err_count;

  led_cmd_t    shown_cmd;
  int unsigned in_gap;
  logic        in_calm;
  int unsigned out_gap;
  logic        out_calm;
  int unsigned hold_left;
  int unsigned hold_mark;

  // Work out the result word of one command and advance the model
  function automatic result_word_t encode_command(input led_cmd_t c);
    result_word_t r;
    logic         row_ok;
    logic [7:0]   sel;
    logic [23:0]  grb;
    int unsigned  cur;
    int unsigned  base;
    r = '0;
    row_ok = c.string_row < ROW_COUNT;
    sel = 8'(1) << c.string_row[2:0];
    case (c.action)
      ACT_CLEAR: begin
        if (tx_active) begin
          r.status = STAT_BUSY;
        end else begin
          for (int k = 0; k < FRAME_BITS; k++) plane_img[k] = '0;
          for (int k = 0; k < ROW_COUNT; k++) cursor_img[k] = 0;
        end
      end
      ACT_ADD: begin
        if (!row_ok) begin
          r.status = STAT_BAD_ROW;
        end else if (tx_active) begin
          r.status = STAT_BUSY;
        end else begin
          // Green goes out first, each byte MSB first
          cur = cursor_img[c.string_row] % LED_COUNT;
          base = cur * BITS_PER_LED;
          grb = {c.green, c.red, c.blue};
          for (int b = 0; b < BITS_PER_LED; b++) begin
            if (grb[BITS_PER_LED-1-b]) plane_img[base+b] = plane_img[base+b] | sel;
            else plane_img[base+b] = plane_img[base+b] & ~sel;
          end
          cur++;
          if (cur >= LED_COUNT) cur = 0;
          cursor_img[c.string_row] = cur;
        end
      end
      ACT_SET: begin
        if (!row_ok) r.status = STAT_BAD_ROW;
        else if (tx_active) r.status = STAT_BUSY;
        else cursor_img[c.string_row] = c.new_index % LED_COUNT;
      end
      ACT_GET: begin
        if (!row_ok) r.status = STAT_BAD_ROW;
        else r.cursor = 6'(cursor_img[c.string_row]);
      end
      ACT_START: begin
        if (tx_active) begin
          r.status = STAT_BUSY;
        end else begin
          tx_active = 1'b1;
          tx_bit = 0;
          tx_slot = 0;
        end
      end
      ACT_TICK: begin
        if (tx_active) begin
          // Slots of one frame bit: all high, data plane, low, low
          if (tx_slot == 0) r.pins = ROW_MASK;
          else if (tx_slot == 1) r.pins = plane_img[tx_bit] & ROW_MASK;
          if (tx_slot == 3) begin
            tx_slot = 0;
            if (tx_bit + 1 >= FRAME_BITS) begin
              r.last = 1'b1;
              tx_active = 1'b0;
              tx_bit = 0;
            end else begin
              tx_bit++;
            end
          end else begin
            tx_slot++;
          end
        end
      end
      default: ;
    endcase
    r.sending = tx_active;
    return r;
  endfunction

  // Append a command word, track the frame state and the cycle budget
  function automatic void queue_cmd(input logic [2:0] act, input logic [7:0] row,
                                    input logic [7:0] idx, input logic [7:0] red,
                                    input logic [7:0] green, input logic [7:0] blue);
    led_cmd_t c;
    c.action = act;
    c.red = red;
    c.green = green;
    c.blue = blue;
    c.string_row = row;
    c.new_index = idx;
    cmd_backlog.push_back(c);
    // Both channels may stall around every word
    run_budget += 34;
    case (act)
      ACT_CLEAR: run_budget += FRAME_BITS + 8;
      ACT_ADD:   run_budget += BITS_PER_LED + 8;
      default:   run_budget += 4;
    endcase
    if (act == ACT_START && !plan_sending) begin
      plan_sending = 1'b1;
      plan_slots_left = FRAME_SLOTS;
    end else if (act == ACT_TICK && plan_sending) begin
      plan_slots_left--;
      if (plan_slots_left == 0) plan_sending = 1'b0;
    end
  endfunction

  // Extremes turn up often, the rest is uniform
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly a real string, now and then an invalid one
  function automatic logic [7:0] rand_row();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(ROW_COUNT, 255));
    return 8'($urandom_range(0, ROW_COUNT - 1));
  endfunction

  task automatic note_mismatch(input string msg);
    err_count++;
    $display("%0t tb_top mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and the cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_limit != 0 && cycle_count > cycle_limit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offer command words from the backlog, predict each one taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    led_cmd_t nxt;
    logic     take;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      take = in_ch.valid && in_ch.ready;
      if (take) begin
        // The word is in: predict its result now, in acceptance order
        result_words_due.push_back(encode_command(shown_cmd));
        cmds_taken <= cmds_taken + 1;
      end
      if (take || !in_ch.valid) begin
        if (in_gap != 0) begin
          // Hold off for the gap drawn with the last word
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          nxt = cmd_backlog.pop_front();
          shown_cmd <= nxt;
          in_ch.action <= nxt.action;
          in_ch.red <= nxt.red;
          in_ch.green <= nxt.green;
          in_ch.blue <= nxt.blue;
          in_ch.string_row <= nxt.string_row;
          in_ch.new_index <= nxt.new_index;
          in_ch.valid <= 1'b1;
          // Flip between gap-free stretches and random gaps now and then
          if ($urandom_range(0, 63) == 0) in_calm <= !in_calm;
          in_gap <= in_calm ? 0 : $urandom_range(0, 15);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take result words with random stalls and check every field
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_proc
    result_word_t want;
    int unsigned  gap;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      gap = out_gap;
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (result_words_due.size() == 0) begin
          note_mismatch("result word with nothing expected");
        end else begin
          want = result_words_due.pop_front();
          if (out_ch.pin_levels !== want.pins)
            note_mismatch($sformatf("pin_levels %h, want %h", out_ch.pin_levels, want.pins));
          if (out_ch.cursor_index !== want.cursor)
            note_mismatch($sformatf("cursor_index %0d, want %0d", out_ch.cursor_index,
                                    want.cursor));
          if (out_ch.status !== want.status)
            note_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
          if (out_ch.sending !== want.sending)
            note_mismatch($sformatf("sending %b, want %b", out_ch.sending, want.sending));
          if (out_ch.last_slot !== want.last)
            note_mismatch($sformatf("last_slot %b, want %b", out_ch.last_slot, want.last));
        end
        if ($urandom_range(0, 63) == 0) out_calm <= !out_calm;
        gap = out_calm ? 0 : $urandom_range(0, 15);
      end else if (gap != 0) begin
        gap--;
      end
      out_gap <= gap;
      out_ch.ready <= (gap == 0) && (hold_left == 0);
    end
  end

  // Long receiver stall, twice: the sender keeps offering, so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((results_seen == 40 || results_seen == 700) && results_seen != hold_mark) begin
      hold_left <= HOLD_CYCLES;
      hold_mark <= results_seen;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stim_proc
    int unsigned idle_words;
    int unsigned pick;
    int unsigned burst;
    logic [7:0]  row;

    // Drive every input to a known value from time zero
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    in_ch.string_row = '0;
    in_ch.new_index = '0;
    out_ch.ready = 1'b0;
    in_calm = 1'b0;
    out_calm = 1'b1;
    cycle_count = 0;
    cycle_limit = 0;
    cmds_taken = 0;
    results_seen = 0;
    err_count = 0;
    hold_mark = 0;

    for (int k = 0; k < FRAME_BITS; k++) plane_img[k] = '0;
    for (int k = 0; k < ROW_COUNT; k++) cursor_img[k] = 0;
    tx_active = 1'b0;
    tx_bit = 0;
    tx_slot = 0;
    plan_sending = 1'b0;
    plan_slots_left = 0;
    // Reset sweep of the store plus the two long receiver holds
    run_budget = FRAME_BITS + 2 * HOLD_CYCLES + 100;

    // Directed: cursor and row corners, spare codes, idle tick, clear
    queue_cmd(ACT_GET,   8'd0,   8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_ADD,   8'd0,   8'h00, 8'h00, 8'hFF, 8'hFF);
    queue_cmd(ACT_ADD,   8'd7,   8'hFF, 8'hFF, 8'h00, 8'h5A);
    queue_cmd(ACT_ADD,   8'd8,   8'h00, 8'h12, 8'h34, 8'h56);
    queue_cmd(ACT_ADD,   8'hFF,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_cmd(ACT_SET,   8'd3,   8'hFF, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_GET,   8'd3,   8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_ADD,   8'd3,   8'h00, 8'h3C, 8'hA5, 8'h81);
    queue_cmd(ACT_GET,   8'd3,   8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_SET,   8'd200, 8'h05, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_GET,   8'd8,   8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_SET,   8'd5,   8'd64, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_SET,   8'd6,   8'h7F, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_TICK,  8'd0,   8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_SPARE_A, 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_cmd(ACT_SPARE_B, 8'd2, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_CLEAR, 8'd0,   8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_GET,   8'd7,   8'h00, 8'h00, 8'h00, 8'h00);

    // Random part: edit traffic while idle
    idle_words = 0;
    while (idle_words < RANDOM_IDLE_WORDS) begin
      pick = $urandom_range(0, 999);
      if (pick < 400) begin
        queue_cmd(ACT_ADD, rand_row(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
        idle_words++;
      end else if (pick < 500) begin
        queue_cmd(ACT_SET, rand_row(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
        idle_words++;
      end else if (pick < 600) begin
        queue_cmd(ACT_GET, rand_row(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
        idle_words++;
      end else if (pick < 650) begin
        queue_cmd(ACT_TICK, rand_row(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
        idle_words++;
      end else if (pick < 675) begin
        queue_cmd(ACT_CLEAR, rand_row(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
        idle_words++;
      end else if (pick < 700) begin
        queue_cmd($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B, rand_row(), rand_byte(),
                  rand_byte(), rand_byte(), rand_byte());
        idle_words++;
      end else begin
        // Place the cursor, paint a run of LEDs, read the cursor back
        row = rand_row();
        burst = $urandom_range(1, 6);
        queue_cmd(ACT_SET, row, rand_byte(), rand_byte(), rand_byte(), rand_byte());
        for (int n = 0; n < burst; n++)
          queue_cmd(ACT_ADD, row, rand_byte(), rand_byte(), rand_byte(), rand_byte());
        queue_cmd(ACT_GET, row, rand_byte(), rand_byte(), rand_byte(), rand_byte());
        idle_words += burst + 2;
      end
    end

    // Start a frame, then try edits while it is on the wire
    queue_cmd(ACT_START, 8'd0,   8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_START, 8'd0,   8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_CLEAR, 8'd0,   8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_ADD,   8'd1,   8'h00, 8'hFF, 8'hFF, 8'hFF);
    queue_cmd(ACT_ADD,   8'd9,   8'h00, 8'hFF, 8'hFF, 8'hFF);
    queue_cmd(ACT_SET,   8'd2,   8'h10, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_GET,   8'd7,   8'h00, 8'h00, 8'h00, 8'h00);

    // Tick through the opening bits of the frame with stray commands mixed in
    for (int n = 0; n < SEND_TAIL_WORDS; n++) begin
      if ($urandom_range(0, 9) != 0)
        queue_cmd(ACT_TICK, rand_row(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
      else
        queue_cmd(3'($urandom_range(ACT_CLEAR, ACT_SPARE_B)), rand_row(), rand_byte(),
                  rand_byte(), rand_byte(), rand_byte());
    end

    total_cmds = cmd_backlog.size();
    cycle_limit = 4 * run_budget + 20000;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every word taken, every result back, then a short quiet tail
    while (cmds_taken != total_cmds || result_words_due.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
